// ----- rtl/core/rtt_est_pkg.sv -----
// rtt_est_pkg: shared types and codes for the round-trip estimator.
// Used by rtt_est_update and rtt_estimator_fault_monitor; no dependencies.
`default_nettype none

package rtt_est_pkg;

   // event codes
   localparam logic [1:0] MODE_SAMPLE  = 2'd0;
   localparam logic [1:0] MODE_TIMEOUT = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;
   localparam logic [1:0] MODE_SET     = 2'd3;

   // fault states
   localparam logic [1:0] FAULT_OK          = 2'd0;
   localparam logic [1:0] FAULT_TEMP        = 2'd1;
   localparam logic [1:0] FAULT_LOCAL_PERM  = 2'd2;
   localparam logic [1:0] FAULT_GLOBAL_PERM = 2'd3;

   // control register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RTT_UPPER_BOUND = 1'd1;

   localparam int unsigned TIMEOUT_W = 17;
   localparam int unsigned RTT_W     = 16;
   localparam int unsigned SAMPLE_W  = 24;

   localparam logic [TIMEOUT_W-1:0] INITIAL_TIMEOUT_RST = 17'd5000;
   localparam logic [RTT_W-1:0]     RTT_UPPER_BOUND_RST = 16'd30000;

   typedef struct packed {
      logic [1:0]          mode;
      logic [SAMPLE_W-1:0] rtt_sample;
      logic [1:0]          new_fault_state;
   } req_type;

   typedef struct packed {
      logic                 monitor_arm;
      logic [TIMEOUT_W-1:0] timeout_value;
      logic [1:0]           fault_state;
      logic                 state_changed;
   } rsp_type;

   // estimator state carried between the state registers and the update logic
   typedef struct packed {
      logic [RTT_W-1:0]     mean_rtt;
      logic [RTT_W-1:0]     mean_deviation;
      logic [TIMEOUT_W-1:0] current_timeout;
      logic [1:0]           peer_state;
   } est_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/rtt_estimator_fault_monitor.sv -----
// rtt_estimator_fault_monitor: round-trip estimator and fault monitor, top level.
// Depends on rtt_est_pkg and rtt_est_update.
//
//   channel | direction | handshake         | word
//   req     | in        | valid / stall     | mode, rtt_sample, new_fault_state
//   rsp     | out       | valid / stall     | monitor_arm, timeout_value, fault_state,
//           |           |                   | state_changed
//   csr     | in        | valid / ready     | index, wdata
//
// One word per cycle sustained while rsp is not stalled. A word sits in the input register,
// the estimator update is combinational and the result lands in the output register
// together with the new estimator state, where rsp valid is raised.
// Reset is synchronous and loads the control registers with their defaults.
// req stalls only when the input register is full and the output register is held.
// csr writes are taken while the input register is empty.
`default_nettype none

module rtt_estimator_fault_monitor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rtt_est_pkg::req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rtt_est_pkg::rsp_type                   rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rtt_est_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtt_est_pkg::TIMEOUT_W-1:0]      csr_wdata
);
   import rtt_est_pkg::*;

   logic                 in_valid_ff;
   req_type              in_data_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rsp_type              out_data_ff;
   est_state_type        est_ff;
   est_state_type        est_in;
   rsp_type              rsp_calc;
   logic [TIMEOUT_W-1:0] init_timeout_ff;
   logic [RTT_W-1:0]     upper_bound_ff;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   rtt_est_update u_update (
      .cur             (est_ff),
      .req             (in_data_ff),
      .initial_timeout (init_timeout_ff),
      .rtt_upper_bound (upper_bound_ff),
      .nxt             (est_in),
      .rsp             (rsp_calc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= rsp_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff.mean_rtt        <= '0;
         est_ff.mean_deviation  <= '0;
         est_ff.current_timeout <= INITIAL_TIMEOUT_RST;
         est_ff.peer_state      <= FAULT_OK;
      end else if (advance) begin
         est_ff <= est_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_timeout_ff <= INITIAL_TIMEOUT_RST;
         upper_bound_ff  <= RTT_UPPER_BOUND_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INITIAL_TIMEOUT: init_timeout_ff <= csr_wdata;
            CSR_RTT_UPPER_BOUND: upper_bound_ff  <= csr_wdata[RTT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // result word always reports the state it left behind
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data.fault_state == est_ff.peer_state) &&
                  (rsp_data.timeout_value == est_ff.current_timeout))
      else $error("result word does not match estimator state");

   // permanent faults never re-arm on samples or timeouts
   a_perm_no_arm: assert property (@(posedge clock) disable iff (reset)
      (advance && est_ff.peer_state[1] &&
       (in_data_ff.mode == MODE_SAMPLE || in_data_ff.mode == MODE_TIMEOUT))
      |=> !rsp_data.monitor_arm && $stable(est_ff))
      else $error("permanent state changed by sample or timeout");

   // restart clears the mean and loads the configured timeout
   a_restart_load: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.mode == MODE_RESTART)
      |=> (est_ff.mean_rtt == '0) && (est_ff.current_timeout == $past(init_timeout_ff)))
      else $error("restart did not reload estimator");

   // a held result keeps the input side from overrunning
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("req stalled with room downstream");

endmodule

`default_nettype wire

// ----- rtl/core/rtt_est_update.sv -----
// rtt_est_update: next-state and result logic for one event.
// Depends on rtt_est_pkg.
`default_nettype none

module rtt_est_update (
   input  rtt_est_pkg::est_state_type          cur,
   input  rtt_est_pkg::req_type                req,
   input  logic [rtt_est_pkg::TIMEOUT_W-1:0]   initial_timeout,
   input  logic [rtt_est_pkg::RTT_W-1:0]       rtt_upper_bound,
   output rtt_est_pkg::est_state_type          nxt,
   output rtt_est_pkg::rsp_type                rsp
);
   import rtt_est_pkg::*;

   logic [RTT_W-1:0]     sat;
   logic [RTT_W:0]       err;       // two's complement, 17 bits
   logic [RTT_W:0]       err_adj;
   logic [RTT_W:0]       mag;
   logic [RTT_W:0]       dmag;
   logic [RTT_W:0]       dmag_adj;
   logic [RTT_W-1:0]     half;
   logic [RTT_W-1:0]     quarter;
   logic [RTT_W-1:0]     mean_n;
   logic [RTT_W-1:0]     dev_n;
   logic [RTT_W-1:0]     bigger;
   logic [TIMEOUT_W-1:0] sample_timeout;
   logic                 live;
   logic                 arm;

   always_comb begin
      sat = (req.rtt_sample > {{(SAMPLE_W-RTT_W){1'b0}}, rtt_upper_bound}) ?
            rtt_upper_bound : req.rtt_sample[RTT_W-1:0];
      err = {1'b0, sat} - {1'b0, cur.mean_rtt};
      // truncate toward zero: bias negatives before the arithmetic shift
      err_adj = err + {{RTT_W{1'b0}}, err[RTT_W]};
      half    = err_adj[RTT_W:1];
      mag     = err[RTT_W] ? (~err + 1'b1) : err;
      dmag    = {1'b0, mag[RTT_W-1:0]} - {1'b0, cur.mean_deviation};
      dmag_adj = dmag + (dmag[RTT_W] ? 17'd3 : 17'd0);
      quarter = {dmag_adj[RTT_W], dmag_adj[RTT_W:2]};
      if (cur.mean_rtt != '0) begin
         mean_n = cur.mean_rtt + half;
         dev_n  = cur.mean_deviation + quarter;
      end else begin
         mean_n = sat;
         dev_n  = sat;
      end
      bigger = (dev_n > mean_n) ? dev_n : mean_n;
      sample_timeout = {1'b0, mean_n} + {1'b0, bigger};
   end

   always_comb begin
      nxt  = cur;
      arm  = 1'b0;
      live = (cur.peer_state == FAULT_OK) || (cur.peer_state == FAULT_TEMP);
      case (req.mode)
         MODE_SAMPLE: begin
            if (live) begin
               nxt.peer_state      = FAULT_OK;
               nxt.mean_rtt        = mean_n;
               nxt.mean_deviation  = dev_n;
               nxt.current_timeout = sample_timeout;
               arm = 1'b1;
            end
         end
         MODE_TIMEOUT: begin
            if (live) begin
               nxt.peer_state = FAULT_TEMP;
               arm = 1'b1;
            end
         end
         MODE_RESTART: begin
            nxt.mean_rtt        = '0;
            nxt.current_timeout = initial_timeout;
            arm = 1'b1;
         end
         default: begin
            nxt.peer_state = req.new_fault_state;
         end
      endcase
      rsp.monitor_arm   = arm;
      rsp.timeout_value = nxt.current_timeout;
      rsp.fault_state   = nxt.peer_state;
      rsp.state_changed = (nxt.peer_state != cur.peer_state);
   end

endmodule

`default_nettype wire

// ----- dv/rtt_monitor_checker.sv -----
// rtt_monitor_checker: watches the req, rsp and csr channels of the RTT estimator and
// fault monitor, predicts each response word and compares it. Depends on rtt_est_pkg.
// Reports its failure count and the number of responses still owed.
`default_nettype none

module rtt_monitor_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  rtt_est_pkg::req_type              req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  rtt_est_pkg::rsp_type              rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [rtt_est_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtt_est_pkg::TIMEOUT_W-1:0] csr_wdata,
   output int                                fail_count,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import rtt_est_pkg::*;

   logic [TIMEOUT_W-1:0] init_timeout_reg = INITIAL_TIMEOUT_RST;
   logic [RTT_W-1:0]     rtt_bound_reg    = RTT_UPPER_BOUND_RST;
   logic [RTT_W-1:0]     mean_q           = '0;
   logic [RTT_W-1:0]     dev_q            = '0;
   logic [TIMEOUT_W-1:0] timeout_q        = INITIAL_TIMEOUT_RST;
   logic [1:0]           fault_q          = FAULT_OK;
   rsp_type              expected_rsp_q[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // advances the estimator by one event word and returns the response it should give
   function automatic rsp_type estimate_event(input req_type w);
      rsp_type    r;
      logic [1:0] prior;
      int         s, err, mag, avg, dv;
      prior = fault_q;
      r.monitor_arm = 1'b0;
      case (w.mode)
         MODE_SAMPLE: begin
            if (fault_q == FAULT_OK || fault_q == FAULT_TEMP) begin
               fault_q = FAULT_OK;
               s = (w.rtt_sample > rtt_bound_reg) ? int'(rtt_bound_reg) : int'(w.rtt_sample);
               if (mean_q != '0) begin
                  err = s - int'(mean_q);
                  mag = (err < 0) ? -err : err;
                  // int division truncates toward zero
                  avg = int'(mean_q) + err / 2;
                  dv  = int'(dev_q) + (mag - int'(dev_q)) / 4;
                  mean_q = avg[RTT_W-1:0];
                  dev_q  = dv[RTT_W-1:0];
               end else begin
                  mean_q = s[RTT_W-1:0];
                  dev_q  = s[RTT_W-1:0];
               end
               timeout_q = TIMEOUT_W'(mean_q)
                         + TIMEOUT_W'((dev_q > mean_q) ? dev_q : mean_q);
               r.monitor_arm = 1'b1;
            end
         end
         MODE_TIMEOUT: begin
            if (fault_q == FAULT_OK || fault_q == FAULT_TEMP) begin
               fault_q = FAULT_TEMP;
               r.monitor_arm = 1'b1;
            end
         end
         MODE_RESTART: begin
            mean_q = '0;
            timeout_q = init_timeout_reg;
            r.monitor_arm = 1'b1;
         end
         default: fault_q = w.new_fault_state;
      endcase
      r.timeout_value = timeout_q;
      r.fault_state   = fault_q;
      r.state_changed = (fault_q != prior);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         init_timeout_reg = INITIAL_TIMEOUT_RST;
         rtt_bound_reg    = RTT_UPPER_BOUND_RST;
         mean_q           = '0;
         dev_q            = '0;
         timeout_q        = INITIAL_TIMEOUT_RST;
         fault_q          = FAULT_OK;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INITIAL_TIMEOUT: init_timeout_reg = csr_wdata;
               CSR_RTT_UPPER_BOUND: rtt_bound_reg = csr_wdata[RTT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(estimate_event(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               // fields: arm/timeout/state/changed
               $display("%0t rsp word with nothing expected: got %0d/%0d/%0d/%0d",
                        $time, rsp_data.monitor_arm, rsp_data.timeout_value,
                        rsp_data.fault_state, rsp_data.state_changed);
            end else begin
               exp_word = expected_rsp_q.pop_front();
               if (rsp_data !== exp_word) begin
                  fail_count++;
                  $display("%0t rsp mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           $time, exp_word.monitor_arm, exp_word.timeout_value,
                           exp_word.fault_state, exp_word.state_changed,
                           rsp_data.monitor_arm, rsp_data.timeout_value,
                           rsp_data.fault_state, rsp_data.state_changed);
               end
            end
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// testbench: drives events and csr writes into rtt_estimator_fault_monitor with random
// idling and backpressure. Depends on rtt_est_pkg, the block's RTL and rtt_monitor_checker.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rtt_est_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 6;
   localparam int PHASE_WORDS = 200;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIMEOUT_W-1:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   int idle_pct    = 27;
   int words_sent  = 0;
   int cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rtt_estimator_fault_monitor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rtt_monitor_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off so the block backs up
   initial begin : rsp_side
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && words_sent >= 150) begin
            held = 1'b1;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   function automatic req_type mk(input logic [1:0] mode, input logic [SAMPLE_W-1:0] smp,
                                  input logic [1:0] nfs);
      req_type w;
      w.mode = mode;
      w.rtt_sample = smp;
      w.new_fault_state = nfs;
      return w;
   endfunction

   // mostly samples near the bound, some full-width, fewer timeouts/restarts/state sets
   function automatic req_type random_event(input logic [RTT_W-1:0] bound);
      req_type w;
      int      pick;
      pick = $urandom_range(99);
      w.rtt_sample = SAMPLE_W'($urandom());
      w.new_fault_state = 2'($urandom_range(3));
      if (pick < 62) begin
         w.mode = MODE_SAMPLE;
         if (pick >= 8)
            w.rtt_sample = SAMPLE_W'($urandom_range(int'(bound) + int'(bound) / 2 + 1));
      end else if (pick < 77) begin
         w.mode = MODE_TIMEOUT;
      end else if (pick < 85) begin
         w.mode = MODE_RESTART;
      end else begin
         w.mode = MODE_SET;
         // keep permanent states short-lived so samples get through
         if ($urandom_range(9) < 7)
            w.new_fault_state = 2'($urandom_range(1));
      end
      return w;
   endfunction

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic configure(input logic [TIMEOUT_W-1:0] init_to,
                            input logic [TIMEOUT_W-1:0] bound);
      csr_valid <= 1'b1;
      csr_index <= CSR_INITIAL_TIMEOUT;
      csr_wdata <= init_to;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_RTT_UPPER_BOUND;
      csr_wdata <= bound;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [TIMEOUT_W-1:0] init_tbl  [PHASES];
      logic [TIMEOUT_W-1:0] bound_tbl [PHASES];
      init_tbl  = '{17'd5000, 17'd1, 17'd131070, 17'd77777,
                    TIMEOUT_W'($urandom_range(1, 131070)), TIMEOUT_W'($urandom_range(1, 131070))};
      // bit 16 of the bound word is dropped by the register
      bound_tbl = '{17'd30000, 17'd1, 17'd65535, 17'd0, 17'h103E8,
                    TIMEOUT_W'($urandom_range(1, 65535))};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset defaults
      send_word(mk(MODE_SAMPLE, 24'd0, FAULT_OK));          // zero sample into zero mean
      send_word(mk(MODE_SAMPLE, 24'hFFFFFF, FAULT_OK));     // saturates, loads mean
      send_word(mk(MODE_SAMPLE, 24'd1, FAULT_OK));
      send_word(mk(MODE_SAMPLE, 24'd17, FAULT_GLOBAL_PERM));
      send_word(mk(MODE_TIMEOUT, 24'd0, FAULT_OK));         // ok -> temp
      send_word(mk(MODE_TIMEOUT, 24'hAAAAAA, FAULT_LOCAL_PERM));
      send_word(mk(MODE_SAMPLE, 24'h555555, FAULT_TEMP));   // temp cleared
      send_word(mk(MODE_RESTART, 24'd0, FAULT_OK));
      send_word(mk(MODE_SAMPLE, 24'd40, FAULT_OK));
      send_word(mk(MODE_SET, 24'd0, FAULT_LOCAL_PERM));
      send_word(mk(MODE_SAMPLE, 24'd100, FAULT_OK));        // ignored in permanent state
      send_word(mk(MODE_TIMEOUT, 24'd0, FAULT_OK));
      send_word(mk(MODE_RESTART, 24'd0, FAULT_OK));
      send_word(mk(MODE_SET, 24'd0, FAULT_GLOBAL_PERM));
      send_word(mk(MODE_SET, 24'd0, FAULT_GLOBAL_PERM));    // no change
      send_word(mk(MODE_SET, 24'd0, FAULT_TEMP));
      send_word(mk(MODE_SET, 24'hFFFFFF, FAULT_OK));
      drain();

      configure(17'd131070, 17'd65535);
      send_word(mk(MODE_RESTART, 24'd0, FAULT_OK));
      send_word(mk(MODE_SAMPLE, 24'hFFFFFF, FAULT_OK));     // largest timeout
      send_word(mk(MODE_SAMPLE, 24'd0, FAULT_OK));
      drain();

      configure(17'd1, 17'd0);                              // every sample clamps to zero
      send_word(mk(MODE_RESTART, 24'd0, FAULT_OK));
      send_word(mk(MODE_SAMPLE, 24'd1234, FAULT_OK));
      send_word(mk(MODE_TIMEOUT, 24'd0, FAULT_OK));

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         configure(init_tbl[ph], bound_tbl[ph]);
         idle_pct = (ph == 2) ? 0 : 27;
         for (int k = 0; k < PHASE_WORDS; k++)
            send_word(random_event(bound_tbl[ph][RTT_W-1:0]));
      end
      drain();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
